// ===== rtl/wbts_pkg.sv =====
// ============================================================================
// wbts_pkg - shared types and constants of the windowed bilinear texel sampler
// Register indexes, opcodes, sequencer states and default parameter values.
// ============================================================================
package wbts_pkg;

    localparam int BAND_SLOTS          = 4;
    localparam int BAND_W              = 16;
    localparam int SCALE_FRAC_BITS     = 8;
    localparam int CFG_W               = 32;
    localparam int CFG_IDX_W           = 3;

    localparam int DEF_BANDS           = 4;
    localparam int DEF_TILE_TEXELS     = 4096;
    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam logic [15:0] RST_RASTER_WIDTH = 16'd1;
    localparam logic [15:0] RST_OUT_SCALE    = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RASTER_WIDTH = 3'd0,
        REG_PRI_ORIGIN   = 3'd1,
        REG_PRI_SIZE     = 3'd2,
        REG_SEC_ORIGIN   = 3'd3,
        REG_SEC_SIZE     = 3'd4,
        REG_WIN_ENABLE   = 3'd5,
        REG_OUT_SCALE    = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_ADDR,
        ST_READ,
        ST_DRAIN,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        hit;
        logic        sel;
        logic [15:0] w;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
    } t_win_res;

    typedef struct packed {
        logic clr;
        logic acc_en;
        logic scl_lo;
        logic scl_hi;
    } t_lane_ctl;

endpackage

// ===== rtl/windowed_bilinear_texel_sampler_top.sv =====
// ============================================================================
// windowed_bilinear_texel_sampler_top - windowed bilinear texel sampler
// Two texel tile stores, window test, four band lanes and the sequencer.
// ============================================================================
// Usage:
//   An item is taken at a clock edge with i_start high and o_busy low.
//   A load item (i_opcode = load) writes one texel into the store chosen by
//   i_store_select at that same edge and produces no result; loads go at
//   one per cycle while no sample is in flight, and o_busy stays low.
//   A sample item keeps o_busy high through the window test, address and
//   weight set-up, four neighbour reads from the single-ported tile store,
//   a drain step, two scale half-products and the final saturation.
//   The result is shown for one cycle with o_valid high in the first cycle
//   with o_busy low again; a new item may be given in that cycle. A point
//   outside both windows goes from the window test straight to the final
//   step, with o_hit low and zero bands.
//   The receiver cannot stall: o_valid is a one-cycle strobe.
//   Configuration goes in through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write only while no sample is in flight; no check is built in.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   restores register defaults; the tile stores keep their contents and
//   a texel must be loaded before it is sampled.
// ============================================================================
module windowed_bilinear_texel_sampler_top
    import wbts_pkg::*;
#(
    parameter int BANDS           = DEF_BANDS,
    parameter int TILE_TEXELS     = DEF_TILE_TEXELS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_opcode,
    input  logic                          i_store_select,
    input  logic [11:0]                   i_texel_address,
    input  logic signed [15:0]            i_load_band0,
    input  logic signed [15:0]            i_load_band1,
    input  logic signed [15:0]            i_load_band2,
    input  logic signed [15:0]            i_load_band3,
    input  logic [16+COORD_FRAC_BITS-1:0] i_sample_x,
    input  logic [16+COORD_FRAC_BITS-1:0] i_sample_y,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_window_used,
    output logic signed [15:0]            o_out_band0,
    output logic signed [15:0]            o_out_band1,
    output logic signed [15:0]            o_out_band2,
    output logic signed [15:0]            o_out_band3
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int SW = 16 + F;
    localparam int AW = $clog2(TILE_TEXELS);
    localparam int DW = BANDS * BAND_W;
    localparam int WW = 2 * F + 1;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // configuration registers
    logic [15:0] r_raster_width, r_out_scale;
    logic [31:0] r_origin [2];
    logic [31:0] r_size   [2];
    logic [1:0]  r_win_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raster_width <= RST_RASTER_WIDTH;
            r_out_scale    <= RST_OUT_SCALE;
            r_origin[0]    <= '0;
            r_origin[1]    <= '0;
            r_size[0]      <= '0;
            r_size[1]      <= '0;
            r_win_en       <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RASTER_WIDTH: r_raster_width <= i_cfg_data[15:0];
                REG_PRI_ORIGIN:   r_origin[0]    <= i_cfg_data;
                REG_PRI_SIZE:     r_size[0]      <= i_cfg_data;
                REG_SEC_ORIGIN:   r_origin[1]    <= i_cfg_data;
                REG_SEC_SIZE:     r_size[1]      <= i_cfg_data;
                REG_WIN_ENABLE:   r_win_en       <= i_cfg_data[1:0];
                REG_OUT_SCALE:    r_out_scale    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    t_state r_state, n_state;
    logic   accept, load_acc, sample_acc;

    assign o_busy     = (r_state != ST_IDLE);
    assign accept     = i_start && !o_busy;
    assign load_acc   = accept && (t_opcode'(i_opcode) == OP_LOAD);
    assign sample_acc = accept && (t_opcode'(i_opcode) == OP_SAMPLE);

    logic [1:0] r_k;
    logic [1:0] r_rd_k;
    logic       r_rd_vld;
    t_win_res   r_win;
    t_win_res   win_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (sample_acc) n_state = ST_TEST;
            ST_TEST:     n_state = win_res.hit ? ST_ADDR : ST_FIN;
            ST_ADDR:     n_state = ST_READ;
            ST_READ:     if (r_k == 2'd3) n_state = ST_DRAIN;
            ST_DRAIN:    n_state = ST_SCALE_LO;
            ST_SCALE_LO: n_state = ST_SCALE_HI;
            ST_SCALE_HI: n_state = ST_FIN;
            ST_FIN:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    t_lane_ctl lane_ctl;
    logic      rd_en;

    always_comb begin
        lane_ctl        = '0;
        rd_en           = 1'b0;
        case (r_state)
            ST_ADDR:     lane_ctl.clr    = 1'b1;
            ST_READ: begin
                rd_en           = 1'b1;
                lane_ctl.acc_en = r_rd_vld;
            end
            ST_DRAIN:    lane_ctl.acc_en = r_rd_vld;
            ST_SCALE_LO: lane_ctl.scl_lo = 1'b1;
            ST_SCALE_HI: lane_ctl.scl_hi = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (r_state == ST_READ) begin
                r_k <= r_k + 2'd1;
            end else begin
                r_k <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
    end

    // window test on the captured point
    logic [SW-1:0] r_sx, r_sy;
    logic [F-1:0]  fx, fy, r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_sx <= i_sample_x;
            r_sy <= i_sample_y;
        end
        if (r_state == ST_TEST) begin
            r_win <= win_res;
            r_fx  <= fx;
            r_fy  <= fy;
        end
    end

    wbts_window #(
        .COORD_FRAC_BITS (F)
    ) u_window (
        .i_sx           (r_sx),
        .i_sy           (r_sy),
        .i_raster_width (r_raster_width),
        .i_origin       (r_origin),
        .i_size         (r_size),
        .i_enable       (r_win_en),
        .o_res          (win_res),
        .o_fx           (fx),
        .o_fy           (fy)
    );

    // row bases and weights
    logic [AW-1:0] r_row0, r_row1;
    logic [WW-1:0] r_wt [4];
    logic [F:0]    wx0, wy0;

    assign wx0 = ONE - {1'b0, r_fx};
    assign wy0 = ONE - {1'b0, r_fy};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR) begin
            r_row0  <= AW'(r_win.y0 * r_win.w);
            r_row1  <= AW'(r_win.y1 * r_win.w);
            r_wt[0] <= WW'(wx0 * wy0);
            r_wt[1] <= WW'({1'b0, r_fx} * wy0);
            r_wt[2] <= WW'(wx0 * {1'b0, r_fy});
            r_wt[3] <= WW'({1'b0, r_fx} * {1'b0, r_fy});
        end
    end

    // tile stores
    logic [AW-1:0]        mem_addr, rd_addr;
    logic [DW-1:0]        wdata;
    logic [DW-1:0]        rdata [2];
    logic signed [15:0]   load_band [BAND_SLOTS];

    assign load_band[0] = i_load_band0;
    assign load_band[1] = i_load_band1;
    assign load_band[2] = i_load_band2;
    assign load_band[3] = i_load_band3;

    for (genvar b = 0; b < BANDS; b++) begin : g_wdata
        assign wdata[b*BAND_W +: BAND_W] =
            BAND_W'($signed(load_band[b][SAMPLE_BITS-1:0]));
    end

    assign rd_addr  = (r_k[1] ? r_row1 : r_row0)
                    + (r_k[0] ? AW'(r_win.x1) : AW'(r_win.x0));
    assign mem_addr = load_acc ? AW'(i_texel_address) : rd_addr;

    for (genvar s = 0; s < 2; s++) begin : g_store
        wbts_tile_mem #(
            .DEPTH (TILE_TEXELS),
            .WIDTH (DW)
        ) u_mem (
            .i_clk   (i_clk),
            .i_we    (load_acc && (i_store_select == 1'(s))),
            .i_re    (rd_en && (r_win.sel == 1'(s))),
            .i_addr  (mem_addr),
            .i_wdata (wdata),
            .o_rdata (rdata[s])
        );
    end

    // band lanes
    logic [DW-1:0]      texel;
    logic signed [15:0] lane_res [BAND_SLOTS];

    assign texel = r_win.sel ? rdata[1] : rdata[0];

    for (genvar b = 0; b < BAND_SLOTS; b++) begin : g_lane
        if (b < BANDS) begin : g_on
            wbts_lane #(
                .COORD_FRAC_BITS (F)
            ) u_lane (
                .i_clk    (i_clk),
                .i_ctl    (lane_ctl),
                .i_sample ($signed(texel[b*BAND_W +: BAND_W])),
                .i_weight (r_wt[r_rd_k]),
                .i_scale  (r_out_scale),
                .o_result (lane_res[b])
            );
        end else begin : g_off
            assign lane_res[b] = '0;
        end
    end

    // result register
    logic               r_valid, r_hit, r_used;
    logic signed [15:0] r_band [BAND_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_hit  <= r_win.hit;
            r_used <= r_win.hit && r_win.sel;
            for (int b = 0; b < BAND_SLOTS; b++) begin
                r_band[b] <= r_win.hit ? lane_res[b] : '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_window_used = r_used;
    assign o_out_band0   = r_band[0];
    assign o_out_band1   = r_band[1];
    assign o_out_band2   = r_band[2];
    assign o_out_band3   = r_band[3];

    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == ST_FIN))
        else $error("result strobe without a finishing step");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_hit) |-> (!r_used && r_band[0] == 16'sd0))
        else $error("miss result carries data");

    a_read_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_READ || r_state == ST_DRAIN))
        else $error("texel read outside the read sequence");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> (r_state == ST_IDLE && !rd_en))
        else $error("texel load collides with a sample read");

endmodule

// ===== rtl/wbts_tile_mem.sv =====
// ============================================================================
// wbts_tile_mem - single-port texel tile store
// One access per cycle, write or read, with registered read data.
// ============================================================================
module wbts_tile_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wbts_window.sv =====
// ============================================================================
// wbts_window - window hit test and neighbour selection
// Tests the primary then the secondary window, wraps x once by the raster
// width, and derives the clamped neighbour columns and rows.
// ============================================================================
module wbts_window
    import wbts_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic [16+COORD_FRAC_BITS-1:0] i_sx,
    input  logic [16+COORD_FRAC_BITS-1:0] i_sy,
    input  logic [15:0]                   i_raster_width,
    input  logic [31:0]                   i_origin [2],
    input  logic [31:0]                   i_size   [2],
    input  logic [1:0]                    i_enable,
    output t_win_res                      o_res,
    output logic [COORD_FRAC_BITS-1:0]    o_fx,
    output logic [COORD_FRAC_BITS-1:0]    o_fy
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int CW = 16 + F + 2;
    localparam logic signed [CW-1:0] ONE = CW'(1) << F;

    logic signed [CW-1:0] lx [2];
    logic signed [CW-1:0] ly [2];
    logic                 hit [2];

    logic signed [CW-1:0] rw;
    assign rw = $signed({2'b00, i_raster_width, {F{1'b0}}});

    for (genvar g = 0; g < 2; g++) begin : g_win
        logic signed [CW-1:0] x_raw, x_wrap, y_raw, w_lim, h_lim;
        always_comb begin
            x_raw  = $signed({2'b00, i_sx}) - $signed({2'b00, i_origin[g][31:16], {F{1'b0}}});
            y_raw  = $signed({2'b00, i_sy}) - $signed({2'b00, i_origin[g][15:0], {F{1'b0}}});
            x_wrap = (x_raw < 0) ? x_raw + rw : x_raw;
            lx[g]  = (x_wrap >= rw) ? x_wrap - rw : x_wrap;
            ly[g]  = y_raw;
            w_lim  = $signed({2'b00, i_size[g][31:16], {F{1'b0}}}) - ONE;
            h_lim  = $signed({2'b00, i_size[g][15:0], {F{1'b0}}}) - ONE;
            hit[g] = i_enable[g] && (lx[g] >= 0) && (lx[g] <= w_lim)
                     && (ly[g] >= 0) && (ly[g] <= h_lim);
        end
    end

    logic                 sel;
    logic signed [CW-1:0] px, py;
    logic [15:0]          w, h;
    logic [16:0]          x_inc, y_inc;

    always_comb begin
        sel   = !hit[0];
        px    = sel ? lx[1] : lx[0];
        py    = sel ? ly[1] : ly[0];
        w     = sel ? i_size[1][31:16] : i_size[0][31:16];
        h     = sel ? i_size[1][15:0]  : i_size[0][15:0];
        o_res.hit = hit[0] || hit[1];
        o_res.sel = sel;
        o_res.w   = w;
        o_res.x0  = px[F+15:F];
        o_res.y0  = py[F+15:F];
        x_inc = {1'b0, px[F+15:F]} + 17'd1;
        y_inc = {1'b0, py[F+15:F]} + 17'd1;
        o_res.x1 = (x_inc < ({1'b0, w} - 17'd1)) ? x_inc[15:0] : w - 16'd1;
        o_res.y1 = (y_inc < ({1'b0, h} - 17'd1)) ? y_inc[15:0] : h - 16'd1;
        o_fx = px[F-1:0];
        o_fy = py[F-1:0];
    end

endmodule

// ===== rtl/wbts_lane.sv =====
// ============================================================================
// wbts_lane - one band lane of the bilinear blend
// Accumulates weighted neighbours, scales by the 8.8 factor in two halves,
// truncates toward zero and saturates to signed 16 bits.
// ============================================================================
module wbts_lane
    import wbts_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic                            i_clk,
    input  t_lane_ctl                       i_ctl,
    input  logic signed [BAND_W-1:0]        i_sample,
    input  logic [2*COORD_FRAC_BITS:0]      i_weight,
    input  logic [15:0]                     i_scale,
    output logic signed [BAND_W-1:0]        o_result
);

    localparam int WW    = 2 * COORD_FRAC_BITS + 1;
    localparam int ACC_W = BAND_W + 2 * COORD_FRAC_BITS + 2;
    localparam int PW    = ACC_W + 18;
    localparam int S     = 2 * COORD_FRAC_BITS + SCALE_FRAC_BITS;
    localparam logic signed [PW-1:0] BIAS   = (PW'(1) << S) - PW'(1);
    localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
    localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [PW-1:0]    r_prod;
    logic signed [BAND_W+WW:0] wprod;
    logic signed [ACC_W+8:0] p_lo, p_hi;
    logic signed [PW-1:0]    rounded, q;

    always_comb begin
        wprod = i_sample * $signed({1'b0, i_weight});
        p_lo  = r_acc * $signed({1'b0, i_scale[7:0]});
        p_hi  = r_acc * $signed({1'b0, i_scale[15:8]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(wprod);
        end
        if (i_ctl.scl_lo) begin
            r_prod <= PW'(p_lo);
        end else if (i_ctl.scl_hi) begin
            r_prod <= r_prod + (PW'(p_hi) <<< 8);
        end
    end

    always_comb begin
        rounded = r_prod + (r_prod[PW-1] ? BIAS : '0);
        q       = rounded >>> S;
        if (q > SAT_HI) begin
            o_result = 16'sh7fff;
        end else if (q < SAT_LO) begin
            o_result = 16'sh8000;
        end else begin
            o_result = q[BAND_W-1:0];
        end
    end

endmodule
